// ----- rtl/core/fexp_pkg.sv -----
// Shared constants and helpers for the single-precision expm1 core.
// Holds binary32 constants, the normalize result type and the shift search.
// No dependencies.
package fexp_pkg;

    // binary32 bit patterns
    localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;
    localparam logic [31:0] INF_BITS   = 32'h7f80_0000;
    localparam logic [31:0] QUIET_BIT  = 32'h0040_0000;
    localparam logic [31:0] ONE_BITS   = 32'h3f80_0000;
    localparam logic [31:0] NEG_ONE    = 32'hbf80_0000;
    localparam logic [31:0] NEG_HALF   = 32'hbf00_0000;
    localparam logic [31:0] ZERO_BITS  = 32'h0000_0000;
    localparam logic [31:0] BIG_BOUND  = 32'h42af_5e20;
    localparam logic [31:0] OVF_BOUND  = 32'h42b1_7217;

    // argument reduction
    localparam logic [31:0] INV_LN2    = 32'h3fb8_aa3b;
    localparam logic [31:0] LN2_HI     = 32'h3f31_7200;
    localparam logic [31:0] LN2_LO     = 32'h35bf_be8e;
    localparam logic [31:0] RND_SHIFT  = 32'h4b40_0000;
    localparam logic [31:0] NEG_SHIFT  = 32'hcb40_0000;

    // polynomial coefficients, constant term first
    localparam logic [31:0] POLY_C0    = 32'h3eff_ffff;
    localparam logic [31:0] POLY_C1    = 32'h3e2a_aa57;
    localparam logic [31:0] POLY_C2    = 32'h3d2a_ab9b;
    localparam logic [31:0] POLY_C3    = 32'h3c09_143e;
    localparam logic [31:0] POLY_C4    = 32'h3ab5_aad1;

    typedef struct packed {
        logic [5:0]  lz;
        logic [63:0] m;
    } t_norm;

    // Left-justify a word in six shift steps and report the shift.
    function automatic t_norm f_norm(input logic [63:0] v);
        t_norm r;
        r.m  = v;
        r.lz = '0;
        if (r.m[63:32] == 32'd0) begin
            r.m     = {r.m[31:0], 32'd0};
            r.lz[5] = 1'b1;
        end
        if (r.m[63:48] == 16'd0) begin
            r.m     = {r.m[47:0], 16'd0};
            r.lz[4] = 1'b1;
        end
        if (r.m[63:56] == 8'd0) begin
            r.m     = {r.m[55:0], 8'd0};
            r.lz[3] = 1'b1;
        end
        if (r.m[63:60] == 4'd0) begin
            r.m     = {r.m[59:0], 4'd0};
            r.lz[2] = 1'b1;
        end
        if (r.m[63:62] == 2'd0) begin
            r.m     = {r.m[61:0], 2'd0};
            r.lz[1] = 1'b1;
        end
        if (r.m[63] == 1'b0) begin
            r.m     = {r.m[62:0], 1'b0};
            r.lz[0] = 1'b1;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/float32_expm1_core.sv -----
// Single-precision expm1: takes one binary32 beat per cycle and returns exp(x)-1,
// bit-exact with round-to-nearest-even fused multiply-adds at every step. The
// datapath is ten dependent fused multiply-add units of five stages each,
// plus one output register. Throughput is one beat per cycle; when the output
// beat is not taken the whole pipeline holds, so o_in_ready follows
// (!o_out_valid || i_out_ready). NaN, -0, large negative and overflowing inputs
// travel beside the datapath and replace its result at the output.
// Depends on fexp_pkg and fexp_fma.
module float32_expm1_core
    import fexp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_x_bits,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_y_bits
);

    localparam int LAT = 50;

    logic w_en;
    logic [LAT-1:0] r_vld;
    logic r_out_valid;
    logic [31:0] r_y;

    assign w_en        = !r_out_valid || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_out_valid;
    assign o_y_bits    = r_y;

    // classify the operand
    logic [30:0] w_ax;
    logic        w_nan, w_negz, w_bigneg, w_ovf, w_spc;
    logic [31:0] w_spc_val;

    always_comb begin
        w_ax     = i_x_bits[30:0];
        w_nan    = (w_ax > INF_BITS[30:0]);
        w_negz   = (i_x_bits == SIGN_BIT);
        w_bigneg = i_x_bits[31] && (w_ax >= BIG_BOUND[30:0]);
        w_ovf    = !i_x_bits[31] && (w_ax > OVF_BOUND[30:0]);
        w_spc    = w_nan || w_negz || w_bigneg || w_ovf;
        if (w_nan) begin
            w_spc_val = i_x_bits | QUIET_BIT;
        end else if (w_negz) begin
            w_spc_val = SIGN_BIT;
        end else if (w_bigneg) begin
            w_spc_val = ONE_BITS | SIGN_BIT;
        end else begin
            w_spc_val = INF_BITS;
        end
    end

    // datapath wires
    logic [31:0] w_r, w_jf, w_njf, w_tm1, w_f1, w_f;
    logic [31:0] w_h1, w_h2, w_h3, w_h4, w_ff, w_p, w_y;
    logic [8:0]  w_j, w_jexp;
    logic        w_big;
    logic [31:0] w_t;

    // delay lines
    logic [31:0] r_x_d   [0:9];
    logic [31:0] r_njf_d [0:4];
    logic [31:0] r_f_d   [0:19];
    logic [31:0] r_ff_d  [0:14];
    logic [31:0] r_t_d   [0:39];
    logic [31:0] r_tm1_d [0:34];
    logic        r_big_d [0:44];
    logic        r_spc_d [0:LAT-1];
    logic [31:0] r_sv_d  [0:LAT-1];

    // round to j: r = x/ln2 + 1.5*2^23, so j sits in the low mantissa bits
    fexp_fma u_r (.i_clk, .i_en(w_en), .i_a(INV_LN2), .i_b(i_x_bits),
                  .i_c(RND_SHIFT), .o_y(w_r));
    fexp_fma u_jf (.i_clk, .i_en(w_en), .i_a(w_r), .i_b(ONE_BITS),
                   .i_c(NEG_SHIFT), .o_y(w_jf));

    // scale t = 2^j built in the exponent field; split it when j is 128
    always_comb begin
        w_j    = w_r[8:0];
        w_big  = ($signed(w_j) > 9'sd127);
        w_jexp = w_j + 9'd127;
        w_t    = {1'b0, (w_big ? 8'd254 : w_jexp[7:0]), 23'd0};
        w_njf  = {~w_jf[31], w_jf[30:0]};
    end

    fexp_fma u_tm1 (.i_clk, .i_en(w_en), .i_a(w_t), .i_b(ONE_BITS),
                    .i_c(w_big ? NEG_HALF : NEG_ONE), .o_y(w_tm1));

    // f = x - j*ln2 in two parts
    fexp_fma u_f1 (.i_clk, .i_en(w_en), .i_a(w_njf), .i_b(LN2_HI),
                   .i_c(r_x_d[9]), .o_y(w_f1));
    fexp_fma u_f (.i_clk, .i_en(w_en), .i_a(r_njf_d[4]), .i_b(LN2_LO),
                  .i_c(w_f1), .o_y(w_f));

    // Horner chain and f squared
    fexp_fma u_h1 (.i_clk, .i_en(w_en), .i_a(w_f), .i_b(POLY_C4),
                   .i_c(POLY_C3), .o_y(w_h1));
    fexp_fma u_h2 (.i_clk, .i_en(w_en), .i_a(r_f_d[4]), .i_b(w_h1),
                   .i_c(POLY_C2), .o_y(w_h2));
    fexp_fma u_h3 (.i_clk, .i_en(w_en), .i_a(r_f_d[9]), .i_b(w_h2),
                   .i_c(POLY_C1), .o_y(w_h3));
    fexp_fma u_h4 (.i_clk, .i_en(w_en), .i_a(r_f_d[14]), .i_b(w_h3),
                   .i_c(POLY_C0), .o_y(w_h4));
    fexp_fma u_ff (.i_clk, .i_en(w_en), .i_a(w_f), .i_b(w_f),
                   .i_c(ZERO_BITS), .o_y(w_ff));

    // p = f + f^2*P(f), then y = p*t + (t - 1)
    fexp_fma u_p (.i_clk, .i_en(w_en), .i_a(r_ff_d[14]), .i_b(w_h4),
                  .i_c(r_f_d[19]), .o_y(w_p));
    fexp_fma u_y (.i_clk, .i_en(w_en), .i_a(w_p), .i_b(r_t_d[39]),
                  .i_c(r_tm1_d[34]), .o_y(w_y));

    // advance the delay lines
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x_d[0]   <= i_x_bits;
            r_njf_d[0] <= w_njf;
            r_f_d[0]   <= w_f;
            r_ff_d[0]  <= w_ff;
            r_t_d[0]   <= w_t;
            r_tm1_d[0] <= w_tm1;
            r_big_d[0] <= w_big;
            r_spc_d[0] <= w_spc;
            r_sv_d[0]  <= w_spc_val;
            for (int k = 1; k < 10; k++) r_x_d[k] <= r_x_d[k-1];
            for (int k = 1; k < 5; k++) r_njf_d[k] <= r_njf_d[k-1];
            for (int k = 1; k < 20; k++) r_f_d[k] <= r_f_d[k-1];
            for (int k = 1; k < 15; k++) r_ff_d[k] <= r_ff_d[k-1];
            for (int k = 1; k < 40; k++) r_t_d[k] <= r_t_d[k-1];
            for (int k = 1; k < 35; k++) r_tm1_d[k] <= r_tm1_d[k-1];
            for (int k = 1; k < 45; k++) r_big_d[k] <= r_big_d[k-1];
            for (int k = 1; k < LAT; k++) begin
                r_spc_d[k] <= r_spc_d[k-1];
                r_sv_d[k]  <= r_sv_d[k-1];
            end
        end
    end

    // double the split-scale result, then pick the special value if flagged
    logic [7:0]  w_yef;
    logic [31:0] w_y2, n_y;

    always_comb begin
        w_yef = w_y[30:23];
        if (!r_big_d[44] || (w_yef == 8'hff)) begin
            w_y2 = w_y;
        end else if (w_yef == 8'hfe) begin
            w_y2 = {w_y[31], INF_BITS[30:0]};
        end else if (w_yef == 8'h00) begin
            w_y2 = {w_y[31], w_y[29:0], 1'b0};
        end else begin
            w_y2 = {w_y[31], w_yef + 8'd1, w_y[22:0]};
        end
        n_y = r_spc_d[LAT-1] ? r_sv_d[LAT-1] : w_y2;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_y <= n_y;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vld       <= {r_vld[LAT-2:0], i_in_valid};
            r_out_valid <= r_vld[LAT-1];
        end
    end

    a_tail_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[LAT-1] && w_en |=> r_out_valid)
        else $error("pipeline tail beat did not reach the output register");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("valid bits moved during a stall");

    a_j_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] && !r_spc_d[4] |->
            ($signed(w_j) >= -9'sd127) && ($signed(w_j) <= 9'sd128))
        else $error("reduced exponent j out of range");

endmodule

// ----- rtl/core/fexp_fma.sv -----
// Five-stage binary32 fused multiply-add, round to nearest even, finite operands.
// Uses fexp_pkg for the normalize helper. Advances only while i_en is high.
module fexp_fma
    import fexp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    output logic [31:0] o_y
);

    // stage 1: unpack, multiply, normalize addend
    logic [7:0]  a_ef, b_ef, c_ef, ea, eb, ec;
    logic [23:0] a_m, b_m, c_m;
    t_norm       c_norm;
    logic [47:0] n1_prod, r1_prod;
    logic [9:0]  n1_pe, r1_pe;
    logic        n1_sp, r1_sp, n1_sc, r1_sc, n1_cz, r1_cz;
    logic [23:0] n1_cm, r1_cm;
    logic signed [12:0] n1_ce, r1_ce;

    assign a_ef = i_a[30:23];
    assign b_ef = i_b[30:23];
    assign c_ef = i_c[30:23];
    assign a_m  = {a_ef != 8'd0, i_a[22:0]};
    assign b_m  = {b_ef != 8'd0, i_b[22:0]};
    assign c_m  = {c_ef != 8'd0, i_c[22:0]};
    assign ea   = (a_ef == 8'd0) ? 8'd1 : a_ef;
    assign eb   = (b_ef == 8'd0) ? 8'd1 : b_ef;
    assign ec   = (c_ef == 8'd0) ? 8'd1 : c_ef;

    always_comb begin
        n1_prod = {24'd0, a_m} * {24'd0, b_m};
        n1_pe   = {2'b0, ea} + {2'b0, eb};
        n1_sp   = i_a[31] ^ i_b[31];
        n1_sc   = i_c[31];
        n1_cz   = (c_m == 24'd0);
        c_norm  = f_norm({c_m, 40'd0});
        n1_cm   = c_norm.m[63:40];
        n1_ce   = $signed({5'b0, ec}) - 13'sd174 - $signed({7'b0, c_norm.lz});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_prod <= n1_prod;
            r1_pe   <= n1_pe;
            r1_sp   <= n1_sp;
            r1_sc   <= n1_sc;
            r1_cz   <= n1_cz;
            r1_cm   <= n1_cm;
            r1_ce   <= n1_ce;
        end
    end

    // stage 2: normalize product, pick the larger operand
    t_norm       p_norm;
    logic [47:0] pm, cm48;
    logic signed [12:0] pe, dd;
    logic        pz, pbig;
    logic [47:0] n2_bm, r2_bm, n2_sm, r2_sm;
    logic signed [12:0] n2_be, r2_be;
    logic [5:0]  n2_d, r2_d;
    logic        n2_bs, r2_bs, n2_sub, r2_sub, n2_bz, r2_bz, n2_zs, r2_zs;

    always_comb begin
        p_norm = f_norm({r1_prod, 16'd0});
        pm     = p_norm.m[63:16];
        pe     = $signed({3'b0, r1_pe}) - 13'sd300 - $signed({7'b0, p_norm.lz});
        pz     = (r1_prod == 48'd0);
        cm48   = {r1_cm, 24'd0};
        pbig   = r1_cz || (!pz && (pe >= r1_ce));
        if (pbig) begin
            n2_bm = pm;
            n2_sm = cm48;
            n2_be = pe;
            n2_bs = r1_sp;
            dd    = pe - r1_ce;
        end else begin
            n2_bm = cm48;
            n2_sm = pm;
            n2_be = r1_ce;
            n2_bs = r1_sc;
            dd    = r1_ce - pe;
        end
        n2_d   = (dd[12] || (dd > 13'sd63)) ? 6'd63 : dd[5:0];
        n2_sub = r1_sp ^ r1_sc;
        n2_bz  = pz && r1_cz;
        n2_zs  = r1_sp && r1_sc;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_bm  <= n2_bm;
            r2_sm  <= n2_sm;
            r2_be  <= n2_be;
            r2_bs  <= n2_bs;
            r2_d   <= n2_d;
            r2_sub <= n2_sub;
            r2_bz  <= n2_bz;
            r2_zs  <= n2_zs;
        end
    end

    // stage 3: align the smaller operand with sticky, add or subtract
    logic [50:0] xa, ya, n3_s, r3_s;
    logic [49:0] yfull, ysh;
    logic        ylost, dneg;
    logic [51:0] dw;
    logic        n3_sign, r3_sign, r3_bz, r3_zs;
    logic signed [12:0] n3_e, r3_e;

    always_comb begin
        xa    = {1'b0, r2_bm, 2'b00};
        yfull = {r2_sm, 2'b00};
        ysh   = yfull >> r2_d;
        ylost = |(yfull & ~({50{1'b1}} << r2_d));
        ya    = {1'b0, ysh[49:1], ysh[0] | ylost};
        dw    = {1'b0, xa} - {1'b0, ya};
        dneg  = r2_sub && dw[51];
        if (!r2_sub) begin
            n3_s = xa + ya;
        end else if (dw[51]) begin
            n3_s = ~dw[50:0] + 51'd1;
        end else begin
            n3_s = dw[50:0];
        end
        n3_sign = r2_bs ^ dneg;
        n3_e    = r2_be - 13'sd2;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_s    <= n3_s;
            r3_sign <= n3_sign;
            r3_e    <= n3_e;
            r3_bz   <= r2_bz;
            r3_zs   <= r2_zs;
        end
    end

    // stage 4: normalize the sum
    t_norm       s_norm;
    logic [50:0] n4_sn, r4_sn;
    logic signed [12:0] n4_be, r4_be;
    logic        n4_zero, r4_zero, n4_sign, r4_sign;

    always_comb begin
        s_norm  = f_norm({r3_s, 13'd0});
        n4_sn   = s_norm.m[63:13];
        n4_be   = r3_e + 13'sd177 - $signed({7'b0, s_norm.lz});
        n4_zero = (r3_s == 51'd0);
        // exact zero: both-zero keeps the common sign, cancellation gives +0
        n4_sign = n4_zero ? (r3_bz && r3_zs) : r3_sign;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_sn   <= n4_sn;
            r4_be   <= n4_be;
            r4_zero <= n4_zero;
            r4_sign <= n4_sign;
        end
    end

    // stage 5: denormalize tiny results, round, pack
    logic signed [12:0] amt13;
    logic [5:0]  amt;
    logic [50:0] sdn, sd;
    logic        dlost, tiny, ovf, rnd;
    logic [7:0]  ef;
    logic [30:0] body;
    logic [31:0] n5_y, r5_y;

    always_comb begin
        tiny  = (r4_be <= 13'sd0);
        amt13 = 13'sd1 - r4_be;
        amt   = (amt13 > 13'sd63) ? 6'd63 : amt13[5:0];
        sdn   = r4_sn >> amt;
        dlost = |(r4_sn & ~({51{1'b1}} << amt));
        sd    = tiny ? {sdn[50:1], sdn[0] | dlost} : r4_sn;
        ef    = tiny ? 8'd0 : r4_be[7:0];
        ovf   = (r4_be > 13'sd254);
        rnd   = sd[26] && ((|sd[25:0]) || sd[27]);
        body  = {ef, sd[49:27]} + {30'd0, rnd};
        if (r4_zero) begin
            n5_y = {r4_sign, 31'd0};
        end else if (ovf) begin
            n5_y = {r4_sign, INF_BITS[30:0]};
        end else begin
            n5_y = {r4_sign, body};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_y <= n5_y;
        end
    end

    assign o_y = r5_y;

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for float32_expm1_core: streams binary32 beats and
// compares every output beat with a bit-exact expm1 predictor kept in this file.
// Depends on fexp_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
    import fexp_pkg::*;

    typedef struct {
        logic [31:0] x;
        bit          drain;
    } t_operand;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
    } t_expm1;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_x_bits = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_y_bits;

    t_operand    operand_q[$];
    t_expm1      expm1_q[$];
    int          n_errors = 0;
    int          n_taken = 0;

    float32_expm1_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_x_bits    (i_x_bits),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_y_bits    (o_y_bits)
    );

    always #4 i_clk = ~i_clk;

    // Widen a binary32 pattern to a double value.
    function automatic real sp_to_real(input logic [31:0] b);
        logic [63:0] d;
        real         v;
        if (b[30:23] == 8'hff) begin
            d = {b[31], 11'h7ff, b[22:0], 29'd0};
            v = $bitstoreal(d);
        end else if (b[30:23] == 8'd0) begin
            v = b[22:0] * $bitstoreal({1'b0, 11'd874, 52'd0});
            if (b[31])
                v = -v;
        end else begin
            d = {b[31], 11'(b[30:23] + 896), b[22:0], 29'd0};
            v = $bitstoreal(d);
        end
        return v;
    endfunction

    // Round a double to binary32, nearest even, overflow to inf.
    function automatic logic [31:0] real_to_sp(input real r);
        logic [63:0] b;
        logic [63:0] sig;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        int          ef;
        int          sh;
        b = $realtobits(r);
        if (b[62:52] == 11'h7ff)
            return {b[63], 8'hff, (b[51:0] != 0) ? 23'h400000 : 23'd0};
        if (b[62:52] == 11'd0)
            return {b[63], 31'd0};
        ef  = int'(b[62:52]) - 1023 + 127;
        sig = {11'd0, 1'b1, b[51:0]};
        sh  = (ef >= 1) ? 29 : 29 + 1 - ef;
        if (sh > 62)
            sh = 62;
        q    = sig >> sh;
        rem  = sig & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0]))
            q = q + 1;
        if (ef >= 1) begin
            if (q == 64'd1 << 24) begin
                q  = q >> 1;
                ef = ef + 1;
            end
            if (ef >= 255)
                return {b[63], INF_BITS[30:0]};
            return {b[63], 8'(ef), q[22:0]};
        end
        return {b[63], q[30:0]};
    endfunction

    // a*b + c with a single rounding: exact product, round-to-odd sum.
    function automatic logic [31:0] sp_fma(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
        real         prod;
        real         cd;
        real         s;
        real         bv;
        real         err;
        logic [63:0] sb;
        prod = sp_to_real(a) * sp_to_real(b);
        cd   = sp_to_real(c);
        s    = prod + cd;
        bv   = s - prod;
        err  = (prod - (s - bv)) + (cd - bv);
        sb   = $realtobits(s);
        if (err != 0.0 && sb[0] == 1'b0) begin
            sb = ((err > 0.0) == (s > 0.0)) ? sb + 1 : sb - 1;
            s  = $bitstoreal(sb);
        end
        return real_to_sp(s);
    endfunction

    // Expected exp(x)-1 for one operand.
    function automatic logic [31:0] expm1_of(input logic [31:0] xb);
        logic [31:0] jf;
        logic [31:0] njf;
        logic [31:0] f;
        logic [31:0] h;
        logic [31:0] p;
        logic [31:0] t;
        logic [31:0] y;
        int          j;
        if (xb[30:0] > INF_BITS[30:0])
            return xb | QUIET_BIT;
        if (xb == SIGN_BIT)
            return SIGN_BIT;
        if (xb[31] && xb[30:0] >= BIG_BOUND[30:0])
            return NEG_ONE;
        if (!xb[31] && xb[30:0] > OVF_BOUND[30:0])
            return INF_BITS;
        jf  = real_to_sp(sp_to_real(sp_fma(INV_LN2, xb, RND_SHIFT)) - sp_to_real(RND_SHIFT));
        j   = $rtoi(sp_to_real(jf));
        njf = jf ^ SIGN_BIT;
        f   = sp_fma(njf, LN2_HI, xb);
        f   = sp_fma(njf, LN2_LO, f);
        h   = sp_fma(f, POLY_C4, POLY_C3);
        h   = sp_fma(f, h, POLY_C2);
        h   = sp_fma(f, h, POLY_C1);
        h   = sp_fma(f, h, POLY_C0);
        p   = sp_fma(real_to_sp(sp_to_real(f) * sp_to_real(f)), h, f);
        if (j > 127) begin
            t = (32'(j - 1) << 23) + ONE_BITS;
            y = sp_fma(p, t, real_to_sp(sp_to_real(t) - 0.5));
            y = real_to_sp(2.0 * sp_to_real(y));
        end else begin
            t = (32'(j) << 23) + ONE_BITS;
            y = sp_fma(p, t, real_to_sp(sp_to_real(t) - 1.0));
        end
        return y;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] x,
                                   input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: x=%h got=%h want=%h", what, x, got, want);
        n_errors++;
    endtask

    // Idle chance in percent for sender and receiver, by stage of the run.
    function automatic int send_idle_pct();
        return (n_taken < 600) ? 32 : (n_taken < 1200) ? 72 : 0;
    endfunction

    function automatic int recv_idle_pct();
        return (n_taken < 600) ? 72 : (n_taken < 1200) ? 32 : 0;
    endfunction

    // Driver: hold a beat until taken, then advance from the operand queue.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expm1_q.push_back('{x: i_x_bits, y: expm1_of(i_x_bits)});
                n_taken++;
            end
            if (!(i_in_valid && !o_in_ready)) begin
                if (operand_q.size() != 0
                    && !(operand_q[0].drain && expm1_q.size() != 0)
                    && $urandom_range(99) >= send_idle_pct()) begin
                    i_in_valid <= 1'b1;
                    i_x_bits   <= operand_q.pop_front().x;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each output beat against the oldest expectation.
    always @(posedge i_clk) begin
        t_expm1 e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expm1_q.size() == 0) begin
                report_mismatch("unexpected beat", 32'hx, o_y_bits, 32'hx);
            end else begin
                e = expm1_q.pop_front();
                if (o_y_bits !== e.y)
                    report_mismatch("y_bits", e.x, o_y_bits, e.y);
            end
        end
        i_out_ready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct());
    end

    task automatic add_operand(input logic [31:0] x, input bit drain = 1'b0);
        operand_q.push_back('{x: x, drain: drain});
    endtask

    initial begin
        logic [31:0] r;
        // directed: zeros, NaNs, infinities, bounds, split-scale region
        add_operand(32'h0000_0000);
        add_operand(SIGN_BIT);
        add_operand(32'h7fc0_0001);
        add_operand(32'h7f80_0001);
        add_operand(32'hffbf_ffff);
        add_operand(32'hffff_ffff);
        add_operand(INF_BITS);
        add_operand(INF_BITS | SIGN_BIT);
        add_operand(BIG_BOUND | SIGN_BIT);
        add_operand((BIG_BOUND - 1) | SIGN_BIT);
        add_operand(BIG_BOUND);
        add_operand(OVF_BOUND);
        add_operand(OVF_BOUND + 1);
        add_operand(32'h42b1_7000);
        add_operand(32'h42b1_0000);
        add_operand(32'h0000_0001);
        add_operand(32'h8000_0001);
        add_operand(32'h007f_ffff);
        add_operand(32'h7f7f_ffff);
        add_operand(32'hff7f_ffff);
        add_operand(ONE_BITS);
        add_operand(NEG_ONE);
        add_operand(32'h3f31_7218);
        add_operand(32'h3300_0000);
        for (int i = 0; i < 1800; i++) begin
            case ($urandom_range(9))
                0, 1: r = $urandom();
                2: r = {1'($urandom_range(1)), 8'($urandom_range(8'h85, 8'h84)),
                        23'($urandom())};
                3: r = (($urandom_range(1) ? OVF_BOUND : BIG_BOUND)
                        + 32'($urandom_range(64)) - 32)
                       | {1'($urandom_range(1)), 31'd0};
                default: r = {1'($urandom_range(1)), 8'($urandom_range(133, 100)),
                              23'($urandom())};
            endcase
            add_operand(r, i == 10 || i == 700 || i == 1400);
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (operand_q.size() == 0 && !i_in_valid && expm1_q.size() == 0);
        repeat (80) @(posedge i_clk);
        if (n_errors == 0 && expm1_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog for a stuck handshake.
    initial begin
        #4ms;
        $display("FAILURE");
        $finish;
    end

endmodule
